@@ design/hue_shade_to_rgb_defines.svh @@
// ----------------------------------------------------------------------------
// hue_shade_to_rgb_defines
// assertion macros used by the checker file hsr_checker
// ----------------------------------------------------------------------------
`ifndef HUE_SHADE_TO_RGB_DEFINES_SVH
`define HUE_SHADE_TO_RGB_DEFINES_SVH

// property that holds at every clock edge outside reset
`define HSR_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("hue_shade_to_rgb: invariant violated");

// implication checked at every clock edge outside reset
`define HSR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hue_shade_to_rgb: implication violated");

`endif

@@ design/hsr_pkg.sv @@
// ----------------------------------------------------------------------------
// hsr_pkg
// types and constants of the hue/shade to rgb converter
// ----------------------------------------------------------------------------
package hsr_pkg;

  localparam int unsigned HueW      = 13;
  localparam int unsigned ShadeW    = 11;
  localparam int unsigned RemW      = 10;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned HueFull   = 5760;
  localparam int unsigned HueSector = 960;
  localparam int unsigned ShadeMid  = 512;
  localparam int unsigned ShadeMax  = 1024;
  localparam int unsigned ChanMax   = 255;
  // 255/960 reduces to 17/64
  localparam int unsigned RampMul   = 17;
  localparam int unsigned RampShift = 6;
  localparam int unsigned ShadeShift = 9;
  localparam int unsigned ProdW     = ChanW + RemW;

  typedef enum logic [2:0] {
    SEC_RED_UP   = 3'd0,
    SEC_GRN_DOWN = 3'd1,
    SEC_GRN_UP   = 3'd2,
    SEC_BLU_DOWN = 3'd3,
    SEC_BLU_UP   = 3'd4,
    SEC_RED_DOWN = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HueW-1:0]   hue_angle;
    logic [ShadeW-1:0] shade;
  } hs_item_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // pure color with its shade, handed from the wheel to the shading stages
  typedef struct packed {
    logic                   valid;
    logic [2:0][ChanW-1:0]  chan;
    logic [ShadeW-1:0]      shade;
  } pure_bus_t;

endpackage

@@ design/hue_shade_to_rgb.sv @@
// ----------------------------------------------------------------------------
// hue_shade_to_rgb
// hue and shade position to 8-bit rgb, five-stage pipeline
// ----------------------------------------------------------------------------
// channel   strobe   payload          direction
// command   start    item  (hs_item)  in, refused while busy (never here)
// result    done     result (rgb)     out, one cycle, cannot be held off
//
// one transfer per clock, every cycle; busy is tied low
// pipeline stages in order: wrap, sector split, ramp select, shade product, blend
// done rises when the start transfer leaves the blend stage and stays for one cycle
// synchronous reset clears the valid bits; items in flight are dropped
// ----------------------------------------------------------------------------
module hue_shade_to_rgb (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  hsr_pkg::hs_item_t item,
  output logic              done,
  output hsr_pkg::rgb_t     result
);

  hsr_pkg::pure_bus_t pure_color;

  assign busy = 1'b0;

  hsr_wheel u_wheel (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start & ~busy),
    .in_item    (item),
    .pure_color (pure_color)
  );

  hsr_shade u_shade (
    .clk        (clk),
    .rst        (rst),
    .pure_color (pure_color),
    .out_valid  (done),
    .out_rgb    (result)
  );

endmodule

@@ design/hsr_wheel.sv @@
// ----------------------------------------------------------------------------
// hsr_wheel
// three-stage pipeline: hue wrap, sector split, ramp and channel select
// ----------------------------------------------------------------------------
module hsr_wheel (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  hsr_pkg::hs_item_t  in_item,
  output hsr_pkg::pure_bus_t pure_color
);

  localparam logic [hsr_pkg::HueW-1:0] HueFullC = hsr_pkg::HueW'(hsr_pkg::HueFull);
  localparam logic [hsr_pkg::HueW-1:0] Sec1 = hsr_pkg::HueW'(1 * hsr_pkg::HueSector);
  localparam logic [hsr_pkg::HueW-1:0] Sec2 = hsr_pkg::HueW'(2 * hsr_pkg::HueSector);
  localparam logic [hsr_pkg::HueW-1:0] Sec3 = hsr_pkg::HueW'(3 * hsr_pkg::HueSector);
  localparam logic [hsr_pkg::HueW-1:0] Sec4 = hsr_pkg::HueW'(4 * hsr_pkg::HueSector);
  localparam logic [hsr_pkg::HueW-1:0] Sec5 = hsr_pkg::HueW'(5 * hsr_pkg::HueSector);
  localparam logic [hsr_pkg::ShadeW-1:0] ShadeMaxC = hsr_pkg::ShadeW'(hsr_pkg::ShadeMax);
  localparam logic [hsr_pkg::RemW-1:0] SectorC = hsr_pkg::RemW'(hsr_pkg::HueSector);
  localparam logic [hsr_pkg::ChanW-1:0] Full = hsr_pkg::ChanW'(hsr_pkg::ChanMax);
  localparam logic [hsr_pkg::ChanW-1:0] Zero = '0;

  // stage 1
  logic                       v1;
  logic [hsr_pkg::HueW-1:0]   hue1;
  logic [hsr_pkg::ShadeW-1:0] shade1;
  // stage 2
  logic                       v2;
  hsr_pkg::sector_t           sec2;
  logic [hsr_pkg::RemW-1:0]   rem2;
  logic [hsr_pkg::ShadeW-1:0] shade2;
  // stage 2 combinational
  hsr_pkg::sector_t           sec_next;
  logic [hsr_pkg::HueW-1:0]   rem_wide;
  // stage 3 combinational
  logic [hsr_pkg::RemW-1:0]   ramp_arg;
  logic [hsr_pkg::RemW+4:0]   ramp_prod;
  logic [hsr_pkg::ChanW-1:0]  ramp;
  logic [2:0][hsr_pkg::ChanW-1:0] chan_next;
  // stage 3
  logic                           v3;
  logic [2:0][hsr_pkg::ChanW-1:0] chan3;
  logic [hsr_pkg::ShadeW-1:0]     shade3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // wrap hue into one turn, saturate shade at white
  always_ff @(posedge clk) begin
    hue1   <= (in_item.hue_angle >= HueFullC) ? in_item.hue_angle - HueFullC
                                              : in_item.hue_angle;
    shade1 <= (in_item.shade > ShadeMaxC) ? ShadeMaxC : in_item.shade;
  end

  always_comb begin
    if (hue1 >= Sec5) begin
      sec_next = hsr_pkg::SEC_RED_DOWN;
      rem_wide = hue1 - Sec5;
    end else if (hue1 >= Sec4) begin
      sec_next = hsr_pkg::SEC_BLU_UP;
      rem_wide = hue1 - Sec4;
    end else if (hue1 >= Sec3) begin
      sec_next = hsr_pkg::SEC_BLU_DOWN;
      rem_wide = hue1 - Sec3;
    end else if (hue1 >= Sec2) begin
      sec_next = hsr_pkg::SEC_GRN_UP;
      rem_wide = hue1 - Sec2;
    end else if (hue1 >= Sec1) begin
      sec_next = hsr_pkg::SEC_GRN_DOWN;
      rem_wide = hue1 - Sec1;
    end else begin
      sec_next = hsr_pkg::SEC_RED_UP;
      rem_wide = hue1;
    end
  end

  always_ff @(posedge clk) begin
    sec2   <= sec_next;
    rem2   <= rem_wide[hsr_pkg::RemW-1:0];
    shade2 <= shade1;
  end

  // odd sectors ramp down
  always_comb begin
    ramp_arg  = sec2[0] ? SectorC - rem2 : rem2;
    ramp_prod = (hsr_pkg::RemW+5)'(ramp_arg) * (hsr_pkg::RemW+5)'(hsr_pkg::RampMul);
    ramp      = ramp_prod[hsr_pkg::RampShift +: hsr_pkg::ChanW];
    unique case (sec2)
      hsr_pkg::SEC_RED_UP:   chan_next = {Zero, ramp, Full};
      hsr_pkg::SEC_GRN_DOWN: chan_next = {Zero, Full, ramp};
      hsr_pkg::SEC_GRN_UP:   chan_next = {ramp, Full, Zero};
      hsr_pkg::SEC_BLU_DOWN: chan_next = {Full, ramp, Zero};
      hsr_pkg::SEC_BLU_UP:   chan_next = {Full, Zero, ramp};
      hsr_pkg::SEC_RED_DOWN: chan_next = {ramp, Zero, Full};
      default:               chan_next = {Zero, Zero, Zero};
    endcase
  end

  always_ff @(posedge clk) begin
    chan3  <= chan_next;
    shade3 <= shade2;
  end

  assign pure_color = '{valid: v3, chan: chan3, shade: shade3};

endmodule

@@ design/hsr_shade.sv @@
// ----------------------------------------------------------------------------
// hsr_shade
// two-stage pipeline: per-channel shade product, then blend and output
// ----------------------------------------------------------------------------
module hsr_shade (
  input  logic               clk,
  input  logic               rst,
  input  hsr_pkg::pure_bus_t pure_color,
  output logic               out_valid,
  output hsr_pkg::rgb_t      out_rgb
);

  localparam logic [hsr_pkg::ShadeW-1:0] MidC = hsr_pkg::ShadeW'(hsr_pkg::ShadeMid);

  logic                          v4;
  logic [2:0][hsr_pkg::ProdW-1:0] prod4;
  logic [2:0][hsr_pkg::ChanW-1:0] base4;
  logic                          dark;
  logic [hsr_pkg::RemW-1:0]      factor;
  logic [2:0][hsr_pkg::ChanW-1:0] mult;
  logic [2:0][hsr_pkg::ChanW-1:0] base_next;
  logic [2:0][hsr_pkg::ProdW-1:0] prod_next;
  logic [2:0][hsr_pkg::ChanW-1:0] res_next;

  // darken: c*f/512 ; lighten: c + (255-c)*f/512
  always_comb begin
    dark = (pure_color.shade <= MidC);
    factor = dark ? pure_color.shade[hsr_pkg::RemW-1:0]
                  : hsr_pkg::RemW'(pure_color.shade - MidC);
    for (int i = 0; i < 3; i++) begin
      mult[i]      = dark ? pure_color.chan[i] : ~pure_color.chan[i];
      base_next[i] = dark ? '0 : pure_color.chan[i];
      prod_next[i] = hsr_pkg::ProdW'(mult[i]) * hsr_pkg::ProdW'(factor);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v4 <= pure_color.valid;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    prod4 <= prod_next;
    base4 <= base_next;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_next[i] = base4[i] + hsr_pkg::ChanW'(prod4[i] >> hsr_pkg::ShadeShift);
    end
  end

  always_ff @(posedge clk) begin
    out_rgb.red   <= res_next[0];
    out_rgb.green <= res_next[1];
    out_rgb.blue  <= res_next[2];
  end

endmodule

@@ design/hsr_checker.sv @@
// ----------------------------------------------------------------------------
// hsr_checker
// port-level checks of the hue/shade to rgb converter
// ----------------------------------------------------------------------------
`include "hue_shade_to_rgb_defines.svh"

module hsr_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input hsr_pkg::hs_item_t item,
  input logic              done,
  input hsr_pkg::rgb_t     result
);

  `HSR_ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)
  `HSR_ASSERT_IMPL(a_latency, clk, rst, start && !busy, ##5 done)
  `HSR_ASSERT_IMPL(a_no_spurious, clk, rst, !(start && !busy), ##5 !done)
  `HSR_ASSERT_IMPL(a_black, clk, rst, start && !busy && item.shade == 11'd0, ##5 (result.red == 8'd0 && result.green == 8'd0 && result.blue == 8'd0))
  `HSR_ASSERT_IMPL(a_white, clk, rst, start && !busy && item.shade >= 11'd1024, ##5 (result.red == 8'd255 && result.green == 8'd255 && result.blue == 8'd255))

endmodule

bind hue_shade_to_rgb hsr_checker u_hsr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
